// ----- design/uv_sphere_cell_vertex_generator_assert.svh -----
// assertion macros of the sphere vertex generator top level
`ifndef UV_SPHERE_CELL_VERTEX_GENERATOR_ASSERT_SVH
`define UV_SPHERE_CELL_VERTEX_GENERATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define UVS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define UVS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/uvs_pkg.sv -----
// shared constants and tables of the sphere vertex generator
package uvs_pkg;

	// default sizes
	localparam int MAX_SEGMENTS_DEF = 1024;
	localparam int SINE_DEPTH_DEF   = 1024;

	// field widths
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int IDX_W      = 10;
	localparam int POS_W      = 16;
	localparam int TEX_W      = 17;
	localparam int CORNER_W   = 2;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 88;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_LON = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAT = 2'd1;
	localparam logic [CFG_W-1:0] LON_RESET = 11'd180;
	localparam logic [CFG_W-1:0] LAT_RESET = 11'd360;

	// quarter sine table, Q30 magnitudes
	localparam int SINE_W = 31;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint unsigned TAYLOR_DIV [8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// divider steps resolved per pipeline stage
	localparam int DIV_STEP = 4;

	// cell corners: offsets and emission order
	localparam logic CORNER_DI [4] = '{1'b0, 1'b1, 1'b0, 1'b1};
	localparam logic CORNER_DJ [4] = '{1'b0, 1'b0, 1'b1, 1'b1};
	localparam logic [CORNER_W-1:0] CORNER_SEQ [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd3, 2'd1};
	localparam logic [2:0] LAST_K = 3'd5;

endpackage

// ----- design/uv_sphere_cell_vertex_generator.sv -----
// top level: uv sphere cell to six triangle vertices
//
//  channel  | handshake          | payload
//  s_*      | s_tvalid/s_tready  | s_tdata: cell indices
//  m_*      | m_tvalid/m_tready  | m_tdata: vertex, m_tlast: sixth vertex, m_tuser: bad index
//  cfg_*    | cfg_valid/cfg_ready| cfg_index, cfg_data: segment counts
//
// a new cell can be taken in the slot in which the last vertex of the previous cell issues;
// its six vertices enter the vertex pipeline one per cycle while the pipeline is not held,
// so the single result channel sets the rate at one vertex per cycle.
// reset clears the pipeline valid bits and loads the segment counts 180 and 360.
// a two-entry output buffer decouples m_tready; the whole pipeline holds while it is full.
`include "uv_sphere_cell_vertex_generator_assert.svh"

module uv_sphere_cell_vertex_generator #(
	parameter int MAX_SEGMENTS     = uvs_pkg::MAX_SEGMENTS_DEF,
	parameter int SINE_TABLE_DEPTH = uvs_pkg::SINE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// lon_index [9:0], lat_index [19:10]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [uvs_pkg::IN_TDATA_W-1:0]    s_tdata,
	// pos_x [15:0], pos_y [31:16], pos_z [47:32], tex_u [64:48], tex_v [81:65],
	// corner_id [83:82]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [uvs_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tlast,
	// bad_index [0]
	output logic                              m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [uvs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [uvs_pkg::CFG_W-1:0]         cfg_data
);

	// table depth is taken as a power of two
	localparam int LD    = $clog2(SINE_TABLE_DEPTH);
	localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
	localparam int N_W   = uvs_pkg::IDX_W + 1;
	localparam int DIV_W = (SEG_W > N_W) ? SEG_W : N_W;
	localparam int QB    = LD + 20;
	localparam int NST   = (QB + uvs_pkg::DIV_STEP - 1) / uvs_pkg::DIV_STEP;
	localparam int PH_W  = LD + 19;
	localparam int SW    = uvs_pkg::SINE_W;
	localparam int TEX_W = uvs_pkg::TEX_W;
	localparam int POS_W = uvs_pkg::POS_W;
	localparam logic [PH_W-1:0] QUARTER_PH = PH_W'(SINE_TABLE_DEPTH * 65536);
	localparam logic [TEX_W-1:0] TEX_ONE = 17'd65536;
	localparam logic [61:0] HALF46 = 62'd1 << 45;

	// lanes: sin theta, cos theta, sin phi, cos phi
	localparam int L_ST = 0;
	localparam int L_CT = 1;
	localparam int L_SP = 2;
	localparam int L_CP = 3;

	typedef struct packed {
		logic [uvs_pkg::CORNER_W-1:0] corner_id;
		logic                         last;
		logic                         bad;
	} side_t;

	typedef struct packed {
		logic [LD-1:0] addr;
		logic [15:0]   frac;
		logic          swap;
		logic          neg;
	} lane_t;

	typedef struct packed {
		logic [uvs_pkg::CORNER_W-1:0] corner_id;
		logic [TEX_W-1:0]             tex_v;
		logic [TEX_W-1:0]             tex_u;
		logic signed [POS_W-1:0]      pos_z;
		logic signed [POS_W-1:0]      pos_y;
		logic signed [POS_W-1:0]      pos_x;
		logic                         last;
		logic                         bad;
	} out_t;

	// phase to rom address, fraction, fold and sign
	function automatic lane_t decode_phase(input logic [PH_W-1:0] p);
		lane_t l;
		logic [PH_W-17:0] idx;
		idx = p[PH_W-1:16];
		l.frac = p[15:0];
		l.swap = idx[LD];
		l.neg = idx[LD+1];
		l.addr = idx[LD] ? ~idx[LD-1:0] : idx[LD-1:0];
		return l;
	endfunction

	logic en;
	logic s_fire;

	// configuration registers
	logic [uvs_pkg::CFG_W-1:0] lon_q;
	logic [uvs_pkg::CFG_W-1:0] lat_q;
	logic [SEG_W-1:0] lon_c;
	logic [SEG_W-1:0] lat_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lon_q <= uvs_pkg::LON_RESET;
			lat_q <= uvs_pkg::LAT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == uvs_pkg::REG_LON) begin
				lon_q <= cfg_data;
			end else if (cfg_index == uvs_pkg::REG_LAT) begin
				lat_q <= cfg_data;
			end
		end
	end

	// counts above the maximum are used as the maximum
	assign lon_c = (32'(lon_q) > MAX_SEGMENTS) ? SEG_W'(MAX_SEGMENTS) : SEG_W'(lon_q);
	assign lat_c = (32'(lat_q) > MAX_SEGMENTS) ? SEG_W'(MAX_SEGMENTS) : SEG_W'(lat_q);

	// cell holder, issues six vertices
	logic hold_v_q;
	logic [2:0] k_q;
	logic [uvs_pkg::IDX_W-1:0] lon_i_q;
	logic [uvs_pkg::IDX_W-1:0] lat_i_q;
	logic bad_q;
	logic [uvs_pkg::IDX_W-1:0] in_lon;
	logic [uvs_pkg::IDX_W-1:0] in_lat;

	assign in_lon = s_tdata[9:0];
	assign in_lat = s_tdata[19:10];
	assign s_tready = en && (!hold_v_q || k_q == uvs_pkg::LAST_K);
	assign s_fire = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			k_q <= '0;
		end else if (en) begin
			if (s_fire) begin
				hold_v_q <= 1'b1;
				k_q <= '0;
			end else if (hold_v_q) begin
				if (k_q == uvs_pkg::LAST_K) begin
					hold_v_q <= 1'b0;
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			lon_i_q <= in_lon;
			lat_i_q <= in_lat;
			bad_q <= (32'(in_lon) >= 32'(lon_c)) || (32'(in_lat) >= 32'(lat_c));
		end
	end

	// stage 1: vertex indices
	logic v_s1;
	side_t side_s1;
	logic [N_W-1:0] n_s1;
	logic [N_W-1:0] m_s1;
	logic [uvs_pkg::CORNER_W-1:0] corner_nx;

	assign corner_nx = uvs_pkg::CORNER_SEQ[k_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= hold_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1 <= N_W'(lon_i_q) + N_W'(uvs_pkg::CORNER_DI[corner_nx]);
			m_s1 <= N_W'(lat_i_q) + N_W'(uvs_pkg::CORNER_DJ[corner_nx]);
			side_s1.corner_id <= corner_nx;
			side_s1.last <= (k_q == uvs_pkg::LAST_K);
			side_s1.bad <= bad_q;
		end
	end

	// angle dividers: n / lon and m / lat with fraction bits
	logic [QB-1:0] quo_phi;
	logic [QB-1:0] quo_th;

	uvs_frac_div #(.DW(DIV_W), .QB(QB)) u_div_phi (
		.clk (clk),
		.en  (en),
		.num (DIV_W'(n_s1)),
		.den (DIV_W'(lon_c)),
		.quo (quo_phi)
	);

	uvs_frac_div #(.DW(DIV_W), .QB(QB)) u_div_th (
		.clk (clk),
		.en  (en),
		.num (DIV_W'(m_s1)),
		.den (DIV_W'(lat_c)),
		.quo (quo_th)
	);

	// side band delay matching the dividers
	logic  dly_v_q    [NST];
	side_t dly_side_q [NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NST; s++) begin
				dly_v_q[s] <= 1'b0;
			end
		end else if (en) begin
			dly_v_q[0] <= v_s1;
			for (int s = 1; s < NST; s++) begin
				dly_v_q[s] <= dly_v_q[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dly_side_q[0] <= side_s1;
			for (int s = 1; s < NST; s++) begin
				dly_side_q[s] <= dly_side_q[s-1];
			end
		end
	end

	// stage 2: rounded phases, texture coordinates, lane decode
	logic [QB:0] phi_rnd;
	logic [QB:0] th_rnd;
	logic [PH_W-1:0] ph_sp;
	logic [PH_W-1:0] ph_st;
	logic [18:0] u_rnd;
	logic [18:0] v_rnd;
	lane_t lane_nx [4];

	always_comb begin
		phi_rnd = ({1'b0, quo_phi} + (QB+1)'(1)) >> 1;
		th_rnd = ({2'b0, quo_th[QB-1:1]} + (QB+1)'(1)) >> 1;
		ph_sp = PH_W'(phi_rnd);
		ph_st = PH_W'(th_rnd);
		u_rnd = ({1'b0, quo_phi[QB-1:LD+2]} + 19'd1) >> 1;
		v_rnd = ({1'b0, quo_th[QB-1:LD+2]} + 19'd1) >> 1;
		lane_nx[L_ST] = decode_phase(ph_st);
		lane_nx[L_CT] = decode_phase(ph_st + QUARTER_PH);
		lane_nx[L_SP] = decode_phase(ph_sp);
		lane_nx[L_CP] = decode_phase(ph_sp + QUARTER_PH);
	end

	logic v_s2;
	side_t side_s2;
	lane_t lane_s2 [4];
	logic [TEX_W-1:0] tex_u_s2;
	logic [TEX_W-1:0] tex_v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= dly_v_q[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= dly_side_q[NST-1];
			lane_s2 <= lane_nx;
			tex_u_s2 <= TEX_W'(u_rnd);
			tex_v_s2 <= TEX_ONE - TEX_W'(v_rnd);
		end
	end

	// stage 3: rom words arrive
	logic [2*SW-1:0] rd_s3 [4];

	uvs_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom_th (
		.clk    (clk),
		.en     (en),
		.addr_a (lane_s2[L_ST].addr),
		.addr_b (lane_s2[L_CT].addr),
		.data_a (rd_s3[L_ST]),
		.data_b (rd_s3[L_CT])
	);

	uvs_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom_ph (
		.clk    (clk),
		.en     (en),
		.addr_a (lane_s2[L_SP].addr),
		.addr_b (lane_s2[L_CP].addr),
		.data_a (rd_s3[L_SP]),
		.data_b (rd_s3[L_CP])
	);

	logic v_s3;
	side_t side_s3;
	lane_t lane_s3 [4];
	logic [TEX_W-1:0] tex_u_s3;
	logic [TEX_W-1:0] tex_v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			lane_s3 <= lane_s2;
			tex_u_s3 <= tex_u_s2;
			tex_v_s3 <= tex_v_s2;
		end
	end

	// linear interpolation between neighboring entries, rounded half up
	logic [SW-1:0]        ent_a   [4];
	logic [SW-1:0]        ent_b   [4];
	logic signed [31:0]   ent_dif [4];
	logic signed [48:0]   ip_prod [4];
	logic signed [32:0]   mag_full [4];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			ent_a[l] = lane_s3[l].swap ? rd_s3[l][2*SW-1:SW] : rd_s3[l][SW-1:0];
			ent_b[l] = lane_s3[l].swap ? rd_s3[l][SW-1:0] : rd_s3[l][2*SW-1:SW];
			ent_dif[l] = $signed({1'b0, ent_b[l]}) - $signed({1'b0, ent_a[l]});
			ip_prod[l] = ent_dif[l] * $signed({1'b0, lane_s3[l].frac}) + 49'sd32768;
			mag_full[l] = $signed({2'b0, ent_a[l]}) + 33'(ip_prod[l] >>> 16);
		end
	end

	// stage 4: lane magnitudes
	logic v_s4;
	side_t side_s4;
	logic [SW-1:0] mag_s4 [4];
	logic neg_s4 [4];
	logic [TEX_W-1:0] tex_u_s4;
	logic [TEX_W-1:0] tex_v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			tex_u_s4 <= tex_u_s3;
			tex_v_s4 <= tex_v_s3;
			for (int l = 0; l < 4; l++) begin
				mag_s4[l] <= mag_full[l][SW-1:0];
				neg_s4[l] <= lane_s3[l].neg;
			end
		end
	end

	// stage 5: x and z products, y magnitude
	logic v_s5;
	side_t side_s5;
	logic [2*SW-1:0] prod_x_s5;
	logic [2*SW-1:0] prod_z_s5;
	logic [SW-1:0] mag_y_s5;
	logic neg_x_s5;
	logic neg_y_s5;
	logic neg_z_s5;
	logic [TEX_W-1:0] tex_u_s5;
	logic [TEX_W-1:0] tex_v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			tex_u_s5 <= tex_u_s4;
			tex_v_s5 <= tex_v_s4;
			prod_x_s5 <= (2*SW)'(mag_s4[L_ST]) * (2*SW)'(mag_s4[L_CP]);
			prod_z_s5 <= (2*SW)'(mag_s4[L_ST]) * (2*SW)'(mag_s4[L_SP]);
			mag_y_s5 <= mag_s4[L_CT];
			neg_x_s5 <= neg_s4[L_ST] ^ neg_s4[L_CP];
			neg_z_s5 <= neg_s4[L_ST] ^ neg_s4[L_SP];
			neg_y_s5 <= neg_s4[L_CT];
		end
	end

	// round to q1.14, apply signs, zero fields of a bad cell
	logic [2*SW-1:0] x_rnd;
	logic [2*SW-1:0] z_rnd;
	logic [31:0] y_rnd;
	logic [POS_W-1:0] x_mag;
	logic [POS_W-1:0] y_mag;
	logic [POS_W-1:0] z_mag;
	out_t res_nx;

	always_comb begin
		x_rnd = prod_x_s5 + HALF46;
		z_rnd = prod_z_s5 + HALF46;
		y_rnd = 32'(mag_y_s5) + 32'd32768;
		x_mag = x_rnd[61:46];
		z_mag = z_rnd[61:46];
		y_mag = y_rnd[31:16];
		res_nx.corner_id = side_s5.corner_id;
		res_nx.last = side_s5.last;
		res_nx.bad = side_s5.bad;
		if (side_s5.bad) begin
			res_nx.pos_x = '0;
			res_nx.pos_y = '0;
			res_nx.pos_z = '0;
			res_nx.tex_u = '0;
			res_nx.tex_v = '0;
		end else begin
			res_nx.pos_x = neg_x_s5 ? -x_mag : x_mag;
			res_nx.pos_y = neg_y_s5 ? -y_mag : y_mag;
			res_nx.pos_z = neg_z_s5 ? -z_mag : z_mag;
			res_nx.tex_u = tex_u_s5;
			res_nx.tex_v = tex_v_s5;
		end
	end

	// output register with skid entry
	logic main_v_q;
	logic skid_v_q;
	out_t main_q;
	out_t skid_q;

	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || m_tready) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= v_s5;
			end
		end else if (v_s5 && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || m_tready) begin
			main_q <= skid_v_q ? skid_q : res_nx;
		end else if (en) begin
			skid_q <= res_nx;
		end
	end

	assign m_tvalid = main_v_q;
	assign m_tdata = {4'b0, main_q.corner_id, main_q.tex_v, main_q.tex_u,
		main_q.pos_z, main_q.pos_y, main_q.pos_x};
	assign m_tlast = main_q.last;
	assign m_tuser = main_q.bad;

	`UVS_ASSERT_NOW(a_skid_behind_main, skid_v_q, main_v_q, "skid entry held without output entry")
	`UVS_ASSERT_NOW(a_accept_free_slot, s_fire, !hold_v_q || k_q == uvs_pkg::LAST_K, "cell taken mid run")
	`UVS_ASSERT_NEXT(a_vertex_count, hold_v_q && en && k_q != uvs_pkg::LAST_K, hold_v_q && k_q == $past(k_q) + 3'd1, "vertex counter skipped")
	`UVS_ASSERT_NOW(a_last_corner, main_v_q && main_q.last, main_q.corner_id == uvs_pkg::CORNER_SEQ[uvs_pkg::LAST_K], "last vertex has wrong corner")
	`UVS_ASSERT_NOW(a_bad_zero, main_v_q && main_q.bad, main_q.tex_u == '0 && main_q.pos_y == '0, "bad cell carries data")

endmodule

// ----- design/uvs_frac_div.sv -----
// pipelined restoring divider giving floor(num * 2^(QB-1) / den) for num <= den
module uvs_frac_div #(
	parameter int DW = 11,
	parameter int QB = 30
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QB-1:0] quo
);

	localparam int STEP = uvs_pkg::DIV_STEP;
	localparam int NST  = (QB + STEP - 1) / STEP;
	localparam int RW   = DW + 1;

	logic [RW-1:0] rem_in [NST];
	logic [QB-1:0] quo_in [NST];
	logic [RW-1:0] rem_q  [NST];
	logic [QB-1:0] quo_q  [NST];

	assign quo = quo_q[NST-1];

	for (genvar s = 0; s < NST; s++) begin : g_stage
		logic [RW-1:0] r_nx;
		logic [QB-1:0] q_nx;

		// stage input: operands or previous stage
		if (s == 0) begin : g_first
			assign rem_in[s] = {1'b0, num};
			assign quo_in[s] = '0;
		end else begin : g_next
			assign rem_in[s] = rem_q[s-1];
			assign quo_in[s] = quo_q[s-1];
		end

		// a few quotient bits, integer bit first
		always_comb begin
			r_nx = rem_in[s];
			q_nx = quo_in[s];
			for (int t = 0; t < STEP; t++) begin
				if (s * STEP + t < QB) begin
					if (s * STEP + t != 0) begin
						r_nx = r_nx << 1;
					end
					if (r_nx >= RW'(den)) begin
						r_nx = r_nx - RW'(den);
						q_nx = {q_nx[QB-2:0], 1'b1};
					end else begin
						q_nx = {q_nx[QB-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[s] <= r_nx;
				quo_q[s] <= q_nx;
			end
		end
	end

endmodule

// ----- design/uvs_sine_rom.sv -----
// quarter sine rom, each word holds two neighboring entries, two registered read ports
module uvs_sine_rom #(
	parameter int DEPTH = uvs_pkg::SINE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [$clog2(DEPTH)-1:0]      addr_a,
	input  logic [$clog2(DEPTH)-1:0]      addr_b,
	output logic [2*uvs_pkg::SINE_W-1:0]  data_a,
	output logic [2*uvs_pkg::SINE_W-1:0]  data_b
);

	typedef logic [2*uvs_pkg::SINE_W-1:0] pair_t;
	typedef pair_t rom_t [DEPTH];

	// sine of entry k by truncated taylor series, clamped to [0, 1.0]
	function automatic logic [uvs_pkg::SINE_W-1:0] sine_entry(input longint unsigned k);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x = (k * uvs_pkg::HALF_PI_Q30 + longint'(DEPTH / 2)) / DEPTH;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int t = 1; t <= 8; t++) begin
			term = ((term * x2) >> 30) / uvs_pkg::TAYLOR_DIV[t-1];
			if ((t & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > uvs_pkg::ONE_Q30) begin
			sum = uvs_pkg::ONE_Q30;
		end
		return uvs_pkg::SINE_W'(sum);
	endfunction

	function automatic rom_t build_rom();
		rom_t rom;
		for (int k = 0; k < DEPTH; k++) begin
			rom[k] = {sine_entry(longint'(k + 1)), sine_entry(longint'(k))};
		end
		return rom;
	endfunction

	localparam rom_t ROM = build_rom();

	pair_t rd_a_q;
	pair_t rd_b_q;

	// registered reads, held while the pipeline stalls
	always_ff @(posedge clk) begin
		if (en) begin
			rd_a_q <= ROM[addr_a];
			rd_b_q <= ROM[addr_b];
		end
	end

	assign data_a = rd_a_q;
	assign data_b = rd_b_q;

endmodule

// ----- tb/sv/uv_sphere_vertex_checker.sv -----
// vertex checker: predicts the six vertices of every accepted cell and compares them
`timescale 1ns / 100ps

module uv_sphere_vertex_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [uvs_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [uvs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            m_tlast,
	input  logic                            m_tuser,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [uvs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [uvs_pkg::CFG_W-1:0]       cfg_data,
	output int                              fail_count,
	output int                              vertices_waiting,
	output int                              vertices_seen,
	output int                              bad_cells_seen
);
	import uvs_pkg::*;

	localparam longint unsigned DEPTH = 1024;
	localparam longint unsigned SEG_MAX = 1024;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [16:0] u;
		logic [16:0] v;
		logic [1:0]  corner;
		logic        last;
		logic        bad;
	} vertex_t;

	longint unsigned sine_q30 [0:1024];
	logic [CFG_W-1:0] lon_reg;
	logic [CFG_W-1:0] lat_reg;
	vertex_t pending_vertices [$];

	// quarter sine table by truncated taylor series
	initial begin
		longint unsigned x, x2, term;
		longint sum;
		for (longint unsigned k = 0; k <= DEPTH; k++) begin
			x = (k * HALF_PI_Q30 + DEPTH / 2) / DEPTH;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int t = 0; t < 8; t++) begin
				term = ((term * x2) >> 30) / TAYLOR_DIV[t];
				if (t % 2 == 0)
					sum -= longint'(term);
				else
					sum += longint'(term);
			end
			if (sum < 0)
				sum = 0;
			if (sum > ONE_Q30)
				sum = ONE_Q30;
			sine_q30[k] = longint'(sum);
		end
	end

	// interpolated sine magnitude of a phase, sign returned separately
	function automatic longint unsigned sine_of(input longint unsigned phase, output logic neg);
		longint unsigned idx, frac, quad, r, a, b;
		idx = phase >> 16;
		frac = phase & 64'hFFFF;
		quad = (idx / DEPTH) & 3;
		r = idx % DEPTH;
		if (quad[0]) begin
			a = sine_q30[DEPTH - r];
			b = sine_q30[DEPTH - r - 1];
		end else begin
			a = sine_q30[r];
			b = sine_q30[r + 1];
		end
		neg = quad >= 2;
		return (a * (65536 - frac) + b * frac + 32768) >> 16;
	endfunction

	function automatic logic [15:0] signed_q14(input longint unsigned mag, input logic neg);
		logic [15:0] m;
		m = mag[15:0];
		return neg ? -m : m;
	endfunction

	// one vertex of a cell at emission slot k
	function automatic vertex_t cell_vertex(input longint unsigned i, input longint unsigned j,
			input int k);
		vertex_t vx;
		longint unsigned lon, lat, n, m, pphi, pth, st, ct, sp, cp;
		logic ns_t, nc_t, ns_p, nc_p;
		int c;
		lon = (lon_reg > SEG_MAX) ? SEG_MAX : lon_reg;
		lat = (lat_reg > SEG_MAX) ? SEG_MAX : lat_reg;
		c = CORNER_SEQ[k];
		vx = '0;
		vx.corner = c;
		vx.last = (k == LAST_K);
		vx.bad = (i >= lon) || (j >= lat);
		if (!vx.bad) begin
			n = i + CORNER_DI[c];
			m = j + CORNER_DJ[c];
			pphi = (n * 4 * DEPTH * 65536 + lon / 2) / lon;
			pth = (m * 2 * DEPTH * 65536 + lat / 2) / lat;
			st = sine_of(pth, ns_t);
			ct = sine_of(pth + DEPTH * 65536, nc_t);
			sp = sine_of(pphi, ns_p);
			cp = sine_of(pphi + DEPTH * 65536, nc_p);
			vx.x = signed_q14((st * cp + (64'd1 << 45)) >> 46, ns_t != nc_p);
			vx.y = signed_q14((ct + 32768) >> 16, nc_t);
			vx.z = signed_q14((st * sp + (64'd1 << 45)) >> 46, ns_t != ns_p);
			vx.u = (n * 65536 + lon / 2) / lon;
			vx.v = 65536 - (m * 65536 + lat / 2) / lat;
		end
		return vx;
	endfunction

	assign vertices_waiting = pending_vertices.size();

	// register copy, expectations and comparison
	always @(posedge clk or negedge arst_n) begin
		vertex_t want, got;
		if (!arst_n) begin
			lon_reg <= LON_RESET;
			lat_reg <= LAT_RESET;
			pending_vertices.delete();
			fail_count <= 0;
			vertices_seen <= 0;
			bad_cells_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LON)
					lon_reg <= cfg_data;
				else if (cfg_index == REG_LAT)
					lat_reg <= cfg_data;
			end
			if (s_tvalid && s_tready) begin
				for (int k = 0; k < 6; k++)
					pending_vertices.push_back(cell_vertex(s_tdata[9:0], s_tdata[19:10], k));
			end
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[15:0];
				got.y = m_tdata[31:16];
				got.z = m_tdata[47:32];
				got.u = m_tdata[64:48];
				got.v = m_tdata[81:65];
				got.corner = m_tdata[83:82];
				got.last = m_tlast;
				got.bad = m_tuser;
				vertices_seen <= vertices_seen + 1;
				if (got.bad && got.last)
					bad_cells_seen <= bad_cells_seen + 1;
				if (pending_vertices.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected vertex: %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_vertices.pop_front();
					if (want !== got) begin
						if (fail_count < 10)
							$display({"vertex mismatch: exp x=%h y=%h z=%h u=%h v=%h c=%0d l=%b b=%b",
								" got x=%h y=%h z=%h u=%h v=%h c=%0d l=%b b=%b"},
								want.x, want.y, want.z, want.u, want.v, want.corner, want.last,
								want.bad, got.x, got.y, got.z, got.u, got.v, got.corner,
								got.last, got.bad);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ----- tb/sv/tb_uv_sphere_cell_vertex_generator.sv -----
// testbench top: drives cells and segment counts, gives the verdict
`timescale 1ns / 100ps

module tb_uv_sphere_cell_vertex_generator;
	import uvs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 300000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	int fail_count, vertices_waiting, vertices_seen, bad_cells_seen;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_toggle = 0;
	int hold_left = 0;
	int cells_sent = 0;
	int settings_used = 0;
	int cycles = 0;
	int lon_now = 180;
	int lat_now = 360;

	always #5 clk = ~clk;

	uv_sphere_cell_vertex_generator i_dut (.*);

	uv_sphere_vertex_checker i_checker (.*);

	// receiver: random stalls, plus a long hold when requested
	always @(negedge clk) begin
		bit hold_seen;
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_cell(input int i, input int j);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {4'b0, j[9:0], i[9:0]};
		do @(posedge clk); while (!s_tready);
		cells_sent++;
		@(negedge clk);
	endtask

	// wait for every vertex, then for the pipeline to settle
	task automatic drain();
		s_tvalid <= 0;
		while (vertices_waiting != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
		if (idx == REG_LON)
			lon_now = value;
		else if (idx == REG_LAT)
			lat_now = value;
	endtask

	task automatic set_segments(input int lon, input int lat);
		drain();
		write_reg(REG_LON, lon);
		write_reg(REG_LAT, lat);
		settings_used++;
	endtask

	// mostly in-range cells, some anywhere in the field
	task automatic random_cells(input int count);
		int lon_eff, lat_eff, i, j;
		lon_eff = (lon_now > 1024) ? 1024 : lon_now;
		lat_eff = (lat_now > 1024) ? 1024 : lat_now;
		repeat (count) begin
			if ($urandom_range(9) < 8 && lon_eff > 0 && lat_eff > 0) begin
				i = $urandom_range(lon_eff - 1);
				j = $urandom_range(lat_eff - 1);
			end else begin
				i = $urandom_range(1023);
				j = $urandom_range(1023);
			end
			send_cell(i, j);
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// reset counts: corners of the grid and just past them
		send_cell(0, 0);
		send_cell(179, 359);
		send_cell(180, 0);
		send_cell(0, 360);
		send_cell(1023, 1023);
		send_cell(90, 180);

		// unknown registers must leave the counts alone
		drain();
		write_reg(REG_SPARE_A, 11'h7FF);
		write_reg(REG_SPARE_B, 5);
		send_cell(179, 359);
		send_cell(45, 90);

		// largest grid
		set_segments(1024, 1024);
		send_cell(1023, 1023);
		send_cell(0, 1023);
		send_cell(1023, 0);
		send_cell(512, 512);

		// single cell sphere
		set_segments(1, 1);
		send_cell(0, 0);
		send_cell(1, 0);
		send_cell(0, 1);

		// oversized counts clamp, zero count is always bad
		set_segments(2047, 0);
		send_cell(1023, 0);
		send_cell(0, 0);
		set_segments(1025, 3);
		send_cell(1023, 2);
		send_cell(1023, 3);

		// random phases: receiver stalls most first, then sender idles most, then neither
		set_segments(1024, 1024);
		send_idle_pct = 23;
		recv_idle_pct = 45;
		random_cells(40);
		set_segments(7, 180);
		send_idle_pct = 45;
		recv_idle_pct = 23;
		random_cells(30);
		set_segments(360, 13);
		random_cells(30);
		set_segments(180, 360);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_cells(30);

		// long output hold while cells keep coming
		hold_toggle = ~hold_toggle;
		set_segments(1024, 2);
		hold_toggle = ~hold_toggle;
		random_cells(25);
		set_segments(3, 1024);
		random_cells(25);

		drain();
		$display("covered %0d cells over %0d segment settings, %0d vertices, %0d bad cells",
			cells_sent, settings_used, vertices_seen, bad_cells_seen);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
